FILE: hw/rtl/mfpab_pkg.sv
package mfpab_pkg;

	localparam int POS_BITS = 12;
	localparam int ADDR_BITS = 26;
	localparam int STRIDE_BITS = 15;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [1:0] FMT_RGB332 = 2'd0;
	localparam logic [1:0] FMT_RGB565 = 2'd1;
	localparam logic [1:0] FMT_BGR888 = 2'd2;
	localparam logic [1:0] FMT_XRGB8888 = 2'd3;

	localparam logic MODE_SOLID = 1'b0;
	localparam logic MODE_ALPHA = 1'b1;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_PIXEL_FORMAT = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_BLEND_MODE = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_STRIDE = 2'd2;

	localparam logic [1:0] RESET_PIXEL_FORMAT = FMT_XRGB8888;
	localparam logic RESET_BLEND_MODE = MODE_SOLID;
	localparam logic [STRIDE_BITS-1:0] RESET_ROW_STRIDE = 15'd2560;

	localparam logic [31:0] MASK332 = 32'h0000_38E3;
	localparam logic [31:0] MASK565 = 32'h07E0_F81F;
	localparam logic [31:0] MASK_RB = 32'h00FF_00FF;
	localparam logic [31:0] MASK_G = 32'h0000_FF00;
	localparam int SPREAD332 = 9;
	localparam int SPREAD565 = 16;

	typedef struct packed {
		logic [POS_BITS-1:0] pos_x;
		logic [POS_BITS-1:0] pos_y;
		logic [31:0] dest_pixel;
		logic [31:0] src_color;
	} pixel_req_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] byte_address;
		logic [2:0] byte_count;
		logic [31:0] new_pixel;
	} pixel_res_t;

endpackage

FILE: hw/rtl/multi_format_pixel_alpha_blend.sv
// Pixel write unit for a frame buffer in RGB332, RGB565, 24-bit BGR or 32-bit XRGB.
// Each item on the request channel carries a pixel position, the current
// destination pixel and an ARGB source color. An item is accepted at a rising
// edge where start is high and busy is low; busy is always low, so a new item
// may be issued in every cycle.
// Each item produces one result: the byte address y * stride + x * bytes per
// pixel, the byte count and the new pixel value (solid overwrite or alpha blend).
// The result is registered onto the result port and is marked by done for
// exactly one cycle. The receiver cannot stall the block.
// Throughput is one item per clock; the latency is set by the request register
// and the result register, with the address multipliers and the blend
// multipliers between them.
// The configuration channel is always ready and writes pixel format, blend mode and
// row stride by index; the user must write it only while no item is in flight, as
// the block does not enforce this. Reset clears all items in flight and restores
// 32-bit XRGB, solid mode and a stride of 2560 bytes.
module multi_format_pixel_alpha_blend
	import mfpab_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  pixel_req_t                request,
	output logic                      done,
	output pixel_res_t                result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int CB = (COORD_BITS < POS_BITS) ? COORD_BITS : POS_BITS;
	localparam logic [POS_BITS-1:0] COORD_MASK = POS_BITS'((33'd1 << CB) - 33'd1);

	logic [1:0] fmt_q;
	logic mode_q;
	logic [STRIDE_BITS-1:0] stride_q;

	logic valid_s1;
	pixel_req_t req_s1;
	logic valid_s2;
	pixel_res_t res_s2;

	logic [POS_BITS-1:0] x_m;
	logic [POS_BITS-1:0] y_m;
	logic [2:0] bpp;
	logic [26:0] row_off;
	logic [14:0] col_off;
	logic [31:0] pix;
	pixel_res_t res_d;

	function automatic logic [7:0] blend_332(logic [31:0] dst, logic [31:0] src);
		logic [31:0] d;
		logic [31:0] f;
		logic [31:0] b;
		logic [2:0] a;
		logic [31:0] p;
		logic [31:0] r;
		d = {24'd0, dst[7:0]};
		f = (src | (src << SPREAD332)) & MASK332;
		b = (d | (d << SPREAD332)) & MASK332;
		a = src[31:29];
		p = 32'({29'd0, a} * (f - b));
		r = (b + (p >> 3)) & MASK332;
		r = r | (r >> SPREAD332);
		return r[7:0];
	endfunction

	function automatic logic [15:0] blend_565(logic [31:0] dst, logic [31:0] src);
		logic [31:0] d;
		logic [31:0] f;
		logic [31:0] b;
		logic [4:0] a;
		logic [31:0] p;
		logic [31:0] r;
		d = {16'd0, dst[15:0]};
		f = (src | (src << SPREAD565)) & MASK565;
		b = (d | (d << SPREAD565)) & MASK565;
		a = src[31:27];
		p = 32'({27'd0, a} * (f - b));
		r = (b + (p >> 5)) & MASK565;
		r = r | (r >> SPREAD565);
		return r[15:0];
	endfunction

	function automatic logic [23:0] blend_888(logic [31:0] dst, logic [31:0] src);
		logic [31:0] s;
		logic [31:0] d;
		logic [31:0] p;
		logic [31:0] v;
		logic [23:0] o;
		o = '0;
		for (int k = 0; k < 3; k++) begin
			s = {24'd0, src[8*k +: 8]};
			d = {24'd0, dst[8*k +: 8]};
			p = 32'({24'd0, src[31:24]} * (s - d));
			v = d + (p >> 8);
			o[8*k +: 8] = v[7:0];
		end
		return o;
	endfunction

	function automatic logic [31:0] blend_x888(logic [31:0] dst, logic [31:0] src);
		logic [31:0] fc;
		logic [31:0] fg;
		logic [31:0] bc;
		logic [31:0] bg;
		logic [31:0] pc;
		logic [31:0] pg;
		logic [31:0] rc;
		logic [31:0] rg;
		fc = src & MASK_RB;
		fg = src & MASK_G;
		bc = dst & MASK_RB;
		bg = dst & MASK_G;
		pc = 32'({24'd0, src[31:24]} * (fc - bc));
		pg = 32'({24'd0, src[31:24]} * (fg - bg));
		rc = (bc + (pc >> 8)) & MASK_RB;
		rg = (bg + (pg >> 8)) & MASK_G;
		return rc | rg;
	endfunction

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= RESET_PIXEL_FORMAT;
			mode_q <= RESET_BLEND_MODE;
			stride_q <= RESET_ROW_STRIDE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PIXEL_FORMAT: fmt_q <= cfg_data[1:0];
				CFG_BLEND_MODE: mode_q <= cfg_data[0];
				CFG_ROW_STRIDE: stride_q <= cfg_data[STRIDE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= request;
		end
		if (valid_s1) begin
			res_s2 <= res_d;
		end
	end

	always_comb begin
		x_m = req_s1.pos_x & COORD_MASK;
		y_m = req_s1.pos_y & COORD_MASK;
		bpp = {1'b0, fmt_q} + 3'd1;
		row_off = 27'(y_m) * 27'(stride_q);
		col_off = 15'(x_m) * 15'(bpp);
		if (mode_q == MODE_SOLID) begin
			unique case (fmt_q)
				FMT_RGB332: pix = {24'd0, req_s1.src_color[7:0]};
				FMT_RGB565: pix = {16'd0, req_s1.src_color[15:0]};
				FMT_BGR888: pix = {8'd0, req_s1.src_color[23:0]};
				default: pix = req_s1.src_color;
			endcase
		end else begin
			unique case (fmt_q)
				FMT_RGB332: pix = {24'd0, blend_332(req_s1.dest_pixel, req_s1.src_color)};
				FMT_RGB565: pix = {16'd0, blend_565(req_s1.dest_pixel, req_s1.src_color)};
				FMT_BGR888: pix = {8'd0, blend_888(req_s1.dest_pixel, req_s1.src_color)};
				default: pix = blend_x888(req_s1.dest_pixel, req_s1.src_color);
			endcase
		end
		res_d.byte_address = row_off[ADDR_BITS-1:0] + ADDR_BITS'(col_off);
		res_d.byte_count = bpp;
		res_d.new_pixel = pix;
	end

	assign done = valid_s2;
	assign result = res_s2;

`ifndef SYNTHESIS
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> valid_s1)
		else $error("accepted item did not enter the first stage");

	a_s1_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("item in the first stage produced no result");

	a_count_matches_format: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.byte_count == ({1'b0, fmt_q} + 3'd1)))
		else $error("byte count does not match the pixel format");

	a_top_byte_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !(fmt_q == FMT_XRGB8888 && mode_q == MODE_SOLID))
		|-> (result.new_pixel[31:24] == 8'd0))
		else $error("pixel bits above the format width are set");

	a_rgb332_width: assert property (@(posedge clk) disable iff (!arst_n)
		(done && fmt_q == FMT_RGB332) |-> (result.new_pixel[31:8] == 24'd0))
		else $error("RGB332 pixel wider than one byte");
`endif

endmodule
